[src/csb_pkg.sv]
`default_nettype none
package csb_pkg;

  localparam int SCREEN_W_DEFAULT = 320;
  localparam int SCREEN_H_DEFAULT = 240;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 3;
  localparam int COORD_W   = 10;
  localparam int PIX_W     = 8;
  localparam int ADDR_W    = 17;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_X        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_Y        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLIT_MODE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_COLOR   = 3'd5;

  // blit modes
  localparam logic [1:0] MODE_COPY  = 2'd0;
  localparam logic [1:0] MODE_KEY   = 2'd1;
  localparam logic [1:0] MODE_FORCE = 2'd2;

  // one classified pixel between front and back
  typedef struct packed {
    logic               we;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIX_W-1:0]   data;
    logic               done;
  } entry_t;

  // last index for a size register: 0 acts as 1, above 1024 acts as 1024
  function automatic logic [COORD_W-1:0] last_index(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] m;
    begin
      m = v - 11'd1;
      if (v == '0) begin
        last_index = '0;
      end else if (v > 11'd1024) begin
        last_index = '1;
      end else begin
        last_index = m[COORD_W-1:0];
      end
    end
  endfunction

endpackage
`default_nettype wire

[src/csb_front.sv]
`default_nettype none
module csb_front #(
  parameter int SCREEN_W = csb_pkg::SCREEN_W_DEFAULT,
  parameter int SCREEN_H = csb_pkg::SCREEN_H_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write,
  input  wire logic [csb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [csb_pkg::CFG_W-1:0]   cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [csb_pkg::PIX_W-1:0]   pixel,
  output logic                             push,
  output csb_pkg::entry_t                  push_entry,
  input  wire logic                        q_ready
);

  localparam int CW = csb_pkg::COORD_W;

  logic [csb_pkg::CFG_W-1:0] sprite_width;
  logic [csb_pkg::CFG_W-1:0] sprite_height;
  logic [csb_pkg::CFG_W-1:0] dest_x;
  logic [csb_pkg::CFG_W-1:0] dest_y;
  logic [1:0]                blit_mode;
  logic [csb_pkg::PIX_W-1:0] force_color;

  logic [CW-1:0] column_count;
  logic [CW-1:0] row_count;
  logic [CW-1:0] column_count_next;
  logic [CW-1:0] row_count_next;

  logic [CW+1:0] sx;
  logic [CW+1:0] sy;
  logic          on;
  logic          nonzero;
  logic          we;
  logic          row_end;
  logic          done;
  logic [csb_pkg::PIX_W-1:0] data;

  always_ff @(posedge clk) begin
    if (rst) begin
      sprite_width  <= 11'd1;
      sprite_height <= 11'd1;
      dest_x        <= '0;
      dest_y        <= '0;
      blit_mode     <= csb_pkg::MODE_COPY;
      force_color   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        csb_pkg::REG_SPRITE_WIDTH:  sprite_width  <= cfg_data;
        csb_pkg::REG_SPRITE_HEIGHT: sprite_height <= cfg_data;
        csb_pkg::REG_DEST_X:        dest_x        <= cfg_data;
        csb_pkg::REG_DEST_Y:        dest_y        <= cfg_data;
        csb_pkg::REG_BLIT_MODE:     blit_mode     <= cfg_data[1:0];
        csb_pkg::REG_FORCE_COLOR:   force_color   <= cfg_data[csb_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = q_ready;
  assign push     = in_valid && q_ready;

  // screen position, sign bit on top
  assign sx = {dest_x[csb_pkg::CFG_W-1], dest_x} + {2'b00, column_count};
  assign sy = {dest_y[csb_pkg::CFG_W-1], dest_y} + {2'b00, row_count};

  assign on = !sx[CW+1] && (sx[CW:0] < (CW+1)'(SCREEN_W))
           && !sy[CW+1] && (sy[CW:0] < (CW+1)'(SCREEN_H));

  assign nonzero = (pixel != '0);
  assign row_end = column_count >= csb_pkg::last_index(sprite_width);
  assign done    = row_end && (row_count >= csb_pkg::last_index(sprite_height));

  always_comb begin
    we   = on;
    data = pixel;
    case (blit_mode)
      csb_pkg::MODE_KEY: begin
        we = on && nonzero;
      end
      csb_pkg::MODE_FORCE: begin
        we   = on && nonzero;
        data = force_color;
      end
      default: ;
    endcase
  end

  always_comb begin
    push_entry.we   = we;
    push_entry.col  = we ? sx[CW-1:0] : '0;
    push_entry.row  = we ? sy[CW-1:0] : '0;
    push_entry.data = we ? data : '0;
    push_entry.done = done;
  end

  always_comb begin
    column_count_next = column_count + 1'b1;
    row_count_next    = row_count;
    if (row_end) begin
      column_count_next = '0;
      row_count_next    = done ? '0 : row_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (push) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule
`default_nettype wire

[src/csb_queue.sv]
`default_nettype none
module csb_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  csb_pkg::entry_t      push_entry,
  output logic                 q_ready,
  input  wire logic            pop,
  output logic                 q_valid,
  output csb_pkg::entry_t      q_entry
);

  csb_pkg::entry_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_ready = (count != 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[src/csb_back.sv]
`default_nettype none
module csb_back #(
  parameter int SCREEN_W = csb_pkg::SCREEN_W_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       q_valid,
  input  csb_pkg::entry_t                 q_entry,
  output logic                            pop,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            write_enable,
  output logic [csb_pkg::ADDR_W-1:0]      dest_addr,
  output logic [csb_pkg::PIX_W-1:0]       write_data,
  output logic                            sprite_done
);

  localparam int PROD_W = 2 * csb_pkg::COORD_W;

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] addr_full;

  assign prod      = PROD_W'(q_entry.row) * PROD_W'(SCREEN_W);
  assign addr_full = prod + PROD_W'(q_entry.col);

  // advance when the output register is empty or being drained
  assign pop = q_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      write_enable <= q_entry.we;
      dest_addr    <= addr_full[csb_pkg::ADDR_W-1:0];
      write_data   <= q_entry.data;
      sprite_done  <= q_entry.done;
    end
  end

endmodule
`default_nettype wire

[src/clipped_sprite_blitter.sv]
`default_nettype none
// Sprite blitter: takes the 8-bit indexed pixels of a sprite in raster order and returns one
// frame-buffer write request per pixel (write_enable, dest_addr, write_data, sprite_done).
// Internal column and row counters place each pixel at dest_x + column, dest_y + row; the
// write is enabled only on the SCREEN_W x SCREEN_H screen, and blit_mode may key out zero
// pixels or replace nonzero ones with force_color. Disabled requests carry zero address and
// data, and every pixel is answered even when the sprite is fully off screen. One pixel is
// accepted per clock while the queue has room; the pixel is classified into the queue when it
// is accepted, the row * SCREEN_W multiply-add loads the output register when the entry leaves
// it, and the two-entry queue between the two stages absorbs output stalls. Write the
// configuration registers only while no request is outstanding; counters are never touched by
// a configuration write.
module clipped_sprite_blitter #(
  parameter int SCREEN_W = csb_pkg::SCREEN_W_DEFAULT,
  parameter int SCREEN_H = csb_pkg::SCREEN_H_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [csb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [csb_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [csb_pkg::PIX_W-1:0]     pixel,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               write_enable,
  output logic [csb_pkg::ADDR_W-1:0]         dest_addr,
  output logic [csb_pkg::PIX_W-1:0]          write_data,
  output logic                               sprite_done
);

  logic            push;
  logic            pop;
  logic            q_ready;
  logic            q_valid;
  csb_pkg::entry_t push_entry;
  csb_pkg::entry_t q_entry;

  csb_front #(
    .SCREEN_W(SCREEN_W),
    .SCREEN_H(SCREEN_H)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel      (pixel),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (q_ready)
  );

  csb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (q_ready),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_entry    (q_entry)
  );

  csb_back #(
    .SCREEN_W(SCREEN_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_entry      (q_entry),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .write_enable (write_enable),
    .dest_addr    (dest_addr),
    .write_data   (write_data),
    .sprite_done  (sprite_done)
  );

endmodule
`default_nettype wire

[tb/sv/csb_write_checker.sv]
`timescale 1ns / 1ps
module csb_write_checker
  import csb_pkg::*;
#(
  parameter int SCREEN_W = SCREEN_W_DEFAULT,
  parameter int SCREEN_H = SCREEN_H_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [PIX_W-1:0]     pixel,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 write_enable,
  input  logic [ADDR_W-1:0]    dest_addr,
  input  logic [PIX_W-1:0]     write_data,
  input  logic                 sprite_done,
  output int                   mismatches,
  output int                   outstanding,
  output int                   writes_enabled,
  output int                   sprites_done
);

  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  data;
    logic              done;
  } fb_write_t;

  // shadow of the register file and the raster position
  logic [CFG_W-1:0]   width_reg;
  logic [CFG_W-1:0]   height_reg;
  logic [CFG_W-1:0]   x_reg;
  logic [CFG_W-1:0]   y_reg;
  logic [1:0]         mode_reg;
  logic [PIX_W-1:0]   color_reg;
  logic [COORD_W-1:0] col_cnt;
  logic [COORD_W-1:0] row_cnt;

  fb_write_t expected_writes[$];
  fb_write_t want;
  int        error_cnt;
  int        write_cnt;
  int        end_cnt;

  // place one pixel on screen, decide its write and advance the raster position
  function automatic fb_write_t blit_pixel(input logic [PIX_W-1:0] p);
    fb_write_t   r;
    int          w_last;
    int          h_last;
    int          sx;
    int          sy;
    logic        on;
    logic        row_end;
    logic [31:0] offset;
    begin
      w_last = (width_reg == '0) ? 0 : (width_reg > 11'd1024) ? 1023 : int'(width_reg) - 1;
      h_last = (height_reg == '0) ? 0 : (height_reg > 11'd1024) ? 1023 : int'(height_reg) - 1;
      sx = int'($signed(x_reg)) + int'(col_cnt);
      sy = int'($signed(y_reg)) + int'(row_cnt);
      on = sx >= 0 && sx < SCREEN_W && sy >= 0 && sy < SCREEN_H;
      r.we = on;
      r.data = p;
      if (mode_reg == MODE_KEY) begin
        r.we = on && p != '0;
      end else if (mode_reg == MODE_FORCE) begin
        r.we = on && p != '0;
        r.data = color_reg;
      end
      row_end = int'(col_cnt) >= w_last;
      r.done = row_end && int'(row_cnt) >= h_last;
      offset = sy * SCREEN_W + sx;
      r.addr = r.we ? offset[ADDR_W-1:0] : '0;
      if (!r.we) begin
        r.data = '0;
      end
      if (row_end) begin
        col_cnt = '0;
        row_cnt = r.done ? '0 : row_cnt + 1'b1;
      end else begin
        col_cnt = col_cnt + 1'b1;
      end
      return r;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      width_reg = 11'd1;
      height_reg = 11'd1;
      x_reg = '0;
      y_reg = '0;
      mode_reg = MODE_COPY;
      color_reg = '0;
      col_cnt = '0;
      row_cnt = '0;
      expected_writes.delete();
      error_cnt = 0;
      write_cnt = 0;
      end_cnt = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_writes.size() == 0) begin
          error_cnt++;
          if (error_cnt <= MAX_REPORTS) begin
            $display("%0t: unexpected write request we=%0b addr=%0d data=%02h done=%0b",
                     $realtime, write_enable, dest_addr, write_data, sprite_done);
          end
        end else begin
          want = expected_writes.pop_front();
          if (write_enable !== want.we || dest_addr !== want.addr ||
              write_data !== want.data || sprite_done !== want.done) begin
            error_cnt++;
            if (error_cnt <= MAX_REPORTS) begin
              $display("%0t: write request mismatch: expected we=%0b addr=%0d data=%02h done=%0b",
                       $realtime, want.we, want.addr, want.data, want.done);
              $display("%0t:                         actual   we=%0b addr=%0d data=%02h done=%0b",
                       $realtime, write_enable, dest_addr, write_data, sprite_done);
            end
          end
          if (want.we) write_cnt++;
          if (want.done) end_cnt++;
        end
      end
      if (in_valid && in_ready) begin
        expected_writes.push_back(blit_pixel(pixel));
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_SPRITE_WIDTH:  width_reg = cfg_data;
          REG_SPRITE_HEIGHT: height_reg = cfg_data;
          REG_DEST_X:        x_reg = cfg_data;
          REG_DEST_Y:        y_reg = cfg_data;
          REG_BLIT_MODE:     mode_reg = cfg_data[1:0];
          REG_FORCE_COLOR:   color_reg = cfg_data[PIX_W-1:0];
          default: ;
        endcase
      end
    end
    // publish after the edge so readers at the next edge see settled values
    mismatches <= error_cnt;
    outstanding <= expected_writes.size();
    writes_enabled <= write_cnt;
    sprites_done <= end_cnt;
  end

endmodule

[tb/sv/clipped_sprite_blitter_tb.sv]
`timescale 1ns / 1ps
module clipped_sprite_blitter_tb;
  import csb_pkg::*;

  localparam int WATCHDOG_LIMIT   = 5000;
  localparam int ITEMS_PER_PHASE  = 450;
  localparam int SPRITE_PIXEL_CAP = 160;
  localparam int SETTLE_CYCLES    = 8;

  // indexes past the register file, ignored by the block
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [1:0]           MODE_SPARE   = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [PIX_W-1:0]     pixel;
  logic                 out_valid;
  logic                 out_ready;
  logic                 write_enable;
  logic [ADDR_W-1:0]    dest_addr;
  logic [PIX_W-1:0]     write_data;
  logic                 sprite_done;

  int mismatches;
  int outstanding;
  int writes_enabled;
  int sprites_done;

  int send_idle_pct;
  int recv_stall_pct;
  int pixels_sent;
  int settings_applied;
  int quiet_cycles;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  clipped_sprite_blitter i_dut (.*);

  csb_write_checker u_write_checker (.*);

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles, %0d results still due",
               quiet_cycles, outstanding);
      $display("** clipped_sprite_blitter: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels_sent++;
  endtask

  // hold off the sender until every write request has come back
  task automatic drain_writes();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_sprite(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                            input logic [CFG_W-1:0] x, input logic [CFG_W-1:0] y,
                            input logic [CFG_W-1:0] mode, input logic [CFG_W-1:0] color);
    drain_writes();
    write_reg(REG_SPRITE_WIDTH, w);
    write_reg(REG_SPRITE_HEIGHT, h);
    write_reg(REG_DEST_X, x);
    write_reg(REG_DEST_Y, y);
    write_reg(REG_BLIT_MODE, mode);
    write_reg(REG_FORCE_COLOR, color);
    if ($urandom_range(9) == 0) begin
      write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_W'($urandom));
    end
    cfg_write <= 1'b0;
    settings_applied++;
  endtask

  task automatic run_phase(input int n_items, input int sender_pct, input int receiver_pct);
    int               first;
    int               count;
    int               w_eff;
    int               h_eff;
    logic [CFG_W-1:0] w_raw;
    logic [CFG_W-1:0] h_raw;
    logic [CFG_W-1:0] x_raw;
    logic [CFG_W-1:0] y_raw;
    logic [CFG_W-1:0] mode_raw;
    begin
      send_idle_pct = sender_pct;
      recv_stall_pct <= receiver_pct;
      first = pixels_sent;
      while (pixels_sent - first < n_items) begin
        case ($urandom_range(19))
          0:       w_raw = '0;
          1:       w_raw = CFG_W'($urandom);
          2:       w_raw = CFG_W'($urandom_range(1024, 1));
          default: w_raw = CFG_W'($urandom_range(24, 1));
        endcase
        case ($urandom_range(19))
          0:       h_raw = '0;
          1:       h_raw = CFG_W'($urandom);
          default: h_raw = CFG_W'($urandom_range(12, 1));
        endcase
        // mostly near the screen so clipping hits every edge
        x_raw = ($urandom_range(9) < 2) ? CFG_W'($urandom)
                                        : CFG_W'(int'($urandom_range(380)) - 30);
        y_raw = ($urandom_range(9) < 2) ? CFG_W'($urandom)
                                        : CFG_W'(int'($urandom_range(280)) - 20);
        mode_raw = CFG_W'($urandom_range(3));
        if ($urandom_range(3) == 0) mode_raw[CFG_W-1:2] = 9'($urandom);
        set_sprite(w_raw, h_raw, x_raw, y_raw, mode_raw, CFG_W'($urandom));

        w_eff = (w_raw == '0) ? 1 : (w_raw > 11'd1024) ? 1024 : int'(w_raw);
        h_eff = (h_raw == '0) ? 1 : (h_raw > 11'd1024) ? 1024 : int'(h_raw);
        count = w_eff * h_eff;
        if (count > SPRITE_PIXEL_CAP) count = SPRITE_PIXEL_CAP;
        // cut some sprites short so the next size lands mid-sprite
        if ($urandom_range(9) == 0) count = $urandom_range(count, 1);
        // stop at the phase budget
        if (count > n_items - (pixels_sent - first)) count = n_items - (pixels_sent - first);
        repeat (count) begin
          send_pixel(($urandom_range(9) < 3) ? '0 : PIX_W'($urandom));
        end
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    pixel <= '0;
    cfg_write <= 1'b0;
    cfg_index <= REG_SPRITE_WIDTH;
    cfg_data <= '0;
    out_ready <= 1'b0;
    recv_stall_pct <= 49;
    send_idle_pct = 10;
    pixels_sent = 0;
    settings_applied = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset values: 1x1 sprite at the origin, plain copy
    send_pixel(8'h00);
    send_pixel(8'hFF);

    // zero size acts as 1, bottom-right corner, zero pixel keyed out
    set_sprite(11'd0, 11'd0, 11'd319, 11'd239, MODE_KEY, 11'd0);
    send_pixel(8'h00);
    send_pixel(8'hAA);

    // top-left clip at -1,-1 in force mode
    set_sprite(11'd3, 11'd2, 11'h7FF, 11'h7FF, MODE_FORCE, 11'h05A);
    send_pixel(8'h00);
    send_pixel(8'h01);
    send_pixel(8'hFF);
    send_pixel(8'h80);
    send_pixel(8'h00);
    send_pixel(8'h7F);

    // bottom-right clip in copy mode
    set_sprite(11'd3, 11'd2, 11'd318, 11'd238, MODE_COPY, 11'h7FF);
    send_pixel(8'h55);
    send_pixel(8'h00);
    send_pixel(8'hAA);
    send_pixel(8'hFF);
    send_pixel(8'h01);
    send_pixel(8'hFE);

    // oversize acts as 1024, far negative origin, spare mode copies
    set_sprite(11'h7FF, 11'h401, 11'h400, 11'h400, MODE_SPARE, 11'h0FF);
    send_pixel(8'h12);
    send_pixel(8'h00);
    send_pixel(8'hED);
    send_pixel(8'h3C);

    // shrink the sprite while the column count sits past the new last column
    set_sprite(11'd2, 11'd1, 11'h3FF, 11'h3FF, MODE_COPY, 11'd0);
    send_pixel(8'h9A);
    send_pixel(8'h00);
    send_pixel(8'h65);

    run_phase(ITEMS_PER_PHASE, 10, 49);
    run_phase(ITEMS_PER_PHASE, 49, 10);
    run_phase(ITEMS_PER_PHASE, 0, 0);

    drain_writes();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d pixels over %0d sprite setups in copy, key and force modes",
             pixels_sent, settings_applied);
    $display("frame writes enabled: %0d, sprite ends seen: %0d, mismatches: %0d",
             writes_enabled, sprites_done, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("** clipped_sprite_blitter: PASSED **");
    end else begin
      $display("** clipped_sprite_blitter: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
src/csb_pkg.sv
src/csb_front.sv
src/csb_queue.sv
src/csb_back.sv
src/clipped_sprite_blitter.sv
tb/sv/csb_write_checker.sv
tb/sv/clipped_sprite_blitter_tb.sv
